// File: rtl/lrar_pkg.sv
`timescale 1ns / 1ps

package lrar_pkg;

  // Lag buffer geometry
  localparam int unsigned LagLength = 17;
  localparam int unsigned PtrW      = 5;
  localparam int unsigned WordW     = 32;
  localparam int unsigned FracW     = 23;

  // Seed recurrence, lag pointer starts and rotate amounts
  localparam logic [WordW-1:0] SeedMult   = 32'd2891336453;
  localparam logic [PtrW-1:0]  LeadStart  = 5'd0;
  localparam logic [PtrW-1:0]  TrailStart = 5'(10 % LagLength);
  localparam logic [PtrW-1:0]  PtrLast    = 5'(LagLength - 1);
  localparam int unsigned      RotTrail   = 13;
  localparam int unsigned      RotLead    = 9;

  // Divider step count
  localparam int unsigned        DivSteps = WordW;
  localparam logic [PtrW-1:0]    DivLast  = 5'(DivSteps - 1);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                   modulus_zero;
    logic [WordW-1:0]       remainder;
    logic [FracW-1:0]       unit_fraction;
    logic [WordW-1:0]       raw_bits;
  } result_t;

  // Rotate a word left by a constant amount
  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input int unsigned r);
    rotl = (v << r) | (v >> (WordW - r));
  endfunction

  // Step a lag pointer down with wrap
  function automatic logic [PtrW-1:0] step_down(input logic [PtrW-1:0] p);
    step_down = (p == '0) ? PtrLast : p - 5'd1;
  endfunction

endpackage

// File: rtl/lagged_rotate_add_random_unit.sv
`timescale 1ns / 1ps
// Each draw passes from the input transfer through the lag read and the 32-step restoring
// divider that forms the remainder, then is loaded into the output register.
// A new draw is taken only in the idle state, once the previous draw has been output-loaded.
// Reset: the seed clears to 0 and the lag memory is refilled from it, one word a cycle;
// a seed write starts the same refill. No input is taken meanwhile.
module lagged_rotate_add_random_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Seed register write
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Draw requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] modulus
  // Draw results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata    // [31:0] raw_bits, [54:32] unit_fraction,
                                      // [86:55] remainder, [87] modulus_zero
);

  localparam int unsigned WordW = lrar_pkg::WordW;
  localparam int unsigned PtrW  = lrar_pkg::PtrW;

  lrar_pkg::state_e state_q, state_d;

  logic [WordW-1:0] seed_q;
  logic [PtrW-1:0]  fill_cnt_q;
  logic [PtrW-1:0]  lead_q;
  logic [PtrW-1:0]  trail_q;
  logic [PtrW-1:0]  div_cnt_q;
  logic [WordW-1:0] modulus_q;
  logic [WordW-1:0] word_q;
  logic [WordW-1:0] dividend_q;
  logic [WordW-1:0] rem_q;
  logic             out_valid_q;
  lrar_pkg::result_t out_q;

  // Lag memory and its registered read ports
  logic [WordW-1:0] lag_mem [lrar_pkg::LagLength];
  logic [WordW-1:0] rd_lead_q;
  logic [WordW-1:0] rd_trail_q;
  logic             mem_we;
  logic [PtrW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;

  logic             in_xfer;
  logic             out_free;
  logic [WordW-1:0] seed_next;
  logic [WordW-1:0] draw_word;
  logic [WordW:0]   rem_shift;
  logic             rem_ge;
  logic [WordW-1:0] rem_next;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Seed recurrence and draw word
  assign seed_next = 32'(seed_q * lrar_pkg::SeedMult + 32'd1);
  assign draw_word = 32'(lrar_pkg::rotl(rd_trail_q, lrar_pkg::RotTrail) +
                         lrar_pkg::rotl(rd_lead_q, lrar_pkg::RotLead));

  // One restoring divide step
  assign rem_shift = {rem_q, dividend_q[WordW-1]};
  assign rem_ge    = rem_shift >= {1'b0, modulus_q};
  assign rem_next  = rem_ge ? 32'(rem_shift - {1'b0, modulus_q}) : rem_shift[WordW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrar_pkg::ST_FILL: if (fill_cnt_q == lrar_pkg::PtrLast) state_d = lrar_pkg::ST_IDLE;
      lrar_pkg::ST_IDLE: if (in_xfer) state_d = lrar_pkg::ST_READ;
      lrar_pkg::ST_READ: state_d = lrar_pkg::ST_DIV;
      lrar_pkg::ST_DIV:  if (div_cnt_q == lrar_pkg::DivLast) state_d = lrar_pkg::ST_OUT;
      lrar_pkg::ST_OUT:  if (out_free) state_d = lrar_pkg::ST_IDLE;
      default:           state_d = lrar_pkg::ST_FILL;
    endcase
    if (cfg_we_i) state_d = lrar_pkg::ST_FILL;
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = lead_q;
    mem_wdata     = draw_word;
    unique case (state_q)
      lrar_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_cnt_q;
        mem_wdata = seed_next;
      end
      lrar_pkg::ST_IDLE: s_axis_tready = 1'b1;
      lrar_pkg::ST_READ: mem_we = 1'b1;
      lrar_pkg::ST_DIV,
      lrar_pkg::ST_OUT:  ;
      default:           ;
    endcase
  end

  // Lag memory: one write port, two registered reads at the pointers
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lag_mem[mem_waddr] <= mem_wdata;
    end
    rd_lead_q  <= lag_mem[lead_q];
    rd_trail_q <= lag_mem[trail_q];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrar_pkg::ST_FILL;
      seed_q      <= '0;
      fill_cnt_q  <= '0;
      lead_q      <= lrar_pkg::LeadStart;
      trail_q     <= lrar_pkg::TrailStart;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // Restart the refill from the new seed
        seed_q     <= cfg_wdata_i;
        fill_cnt_q <= '0;
      end else if (state_q == lrar_pkg::ST_FILL) begin
        seed_q     <= seed_next;
        fill_cnt_q <= fill_cnt_q + 5'd1;
        if (fill_cnt_q == lrar_pkg::PtrLast) begin
          lead_q  <= lrar_pkg::LeadStart;
          trail_q <= lrar_pkg::TrailStart;
        end
      end
      if (state_q == lrar_pkg::ST_READ) begin
        // Advance both pointers after the word is written back
        lead_q    <= lrar_pkg::step_down(lead_q);
        trail_q   <= lrar_pkg::step_down(trail_q);
        div_cnt_q <= '0;
      end else if (state_q == lrar_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + 5'd1;
      end
      if (state_q == lrar_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      modulus_q <= s_axis_tdata;
    end
    if (state_q == lrar_pkg::ST_READ) begin
      word_q     <= draw_word;
      dividend_q <= draw_word;
      rem_q      <= '0;
    end else if (state_q == lrar_pkg::ST_DIV) begin
      dividend_q <= dividend_q << 1;
      rem_q      <= rem_next;
    end
    if (state_q == lrar_pkg::ST_OUT && out_free) begin
      out_q.raw_bits      <= word_q;
      out_q.unit_fraction <= word_q[WordW-1 -: lrar_pkg::FracW];
      out_q.modulus_zero  <= (modulus_q == '0);
      out_q.remainder     <= (modulus_q == '0) ? '0 : rem_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  // Pointers keep their fixed distance of ten places around the ring
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lrar_pkg::ST_FILL) |->
      ((trail_q == lead_q + 5'd10) || (trail_q + 5'd7 == lead_q)))
    else $error("lag pointers lost their distance");

  // Pointers stay inside the lag ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lead_q <= lrar_pkg::PtrLast) && (trail_q <= lrar_pkg::PtrLast))
    else $error("lag pointer out of range");

  // A result is loaded only when the divider has finished
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lrar_pkg::ST_OUT))
    else $error("result loaded outside the output step");

  // A zero modulus always reports a zero remainder
  a_zero_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.modulus_zero) |-> (out_q.remainder == '0))
    else $error("nonzero remainder with zero modulus");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned DrainCycles   = 40;

  // Lag-buffer predictor and queue of expected draws
  class draw_scoreboard;
    logic [lrar_pkg::WordW-1:0] lag_q [lrar_pkg::LagLength];
    int unsigned                lead_idx;
    int unsigned                trail_idx;
    lrar_pkg::result_t          expected_q [$];
    int unsigned                error_count;

    // Refill the lag words from a seed by the linear congruential recurrence
    function void reseed(input logic [lrar_pkg::WordW-1:0] seed);
      logic [lrar_pkg::WordW-1:0] s;
      s = seed;
      for (int k = 0; k < lrar_pkg::LagLength; k++) begin
        s = s * 32'd2891336453 + 32'd1;
        lag_q[k] = s;
      end
      lead_idx  = 0;
      trail_idx = 10 % lrar_pkg::LagLength;
    endfunction

    // Advance the generator for one accepted draw and queue its result
    function void note_draw(input logic [lrar_pkg::WordW-1:0] modulus);
      logic [lrar_pkg::WordW-1:0] lead_w;
      logic [lrar_pkg::WordW-1:0] trail_w;
      lrar_pkg::result_t          exp_r;
      lead_w  = lag_q[lead_idx];
      trail_w = lag_q[trail_idx];
      exp_r.raw_bits      = {trail_w[18:0], trail_w[31:19]} + {lead_w[22:0], lead_w[31:23]};
      exp_r.unit_fraction = exp_r.raw_bits[31:9];
      exp_r.modulus_zero  = (modulus == '0);
      exp_r.remainder     = exp_r.modulus_zero ? '0 : exp_r.raw_bits % modulus;
      lag_q[lead_idx] = exp_r.raw_bits;
      lead_idx  = (lead_idx == 0) ? lrar_pkg::LagLength - 1 : lead_idx - 1;
      trail_idx = (trail_idx == 0) ? lrar_pkg::LagLength - 1 : trail_idx - 1;
      expected_q.push_back(exp_r);
    endfunction

    function void report(input string field, input logic [lrar_pkg::WordW-1:0] exp_v,
                         input logic [lrar_pkg::WordW-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $realtime, field, exp_v, act_v);
        error_count++;
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(input lrar_pkg::result_t got);
      lrar_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $realtime, got);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        report("raw_bits", exp_r.raw_bits, got.raw_bits);
        report("unit_fraction", 32'(exp_r.unit_fraction), 32'(got.unit_fraction));
        report("remainder", exp_r.remainder, got.remainder);
        report("modulus_zero", 32'(exp_r.modulus_zero), 32'(got.modulus_zero));
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  logic        src_gaps  = 1'b1;
  logic        sink_gaps = 1'b1;
  int unsigned stall_cycles = 0;

  draw_scoreboard sb = new();

  lagged_rotate_add_random_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Stall the result side at random while sink gaps are enabled
  always @(negedge clk_i) begin
    m_axis_tready <= sink_gaps ? ($urandom_range(0, 99) >= 20) : 1'b1;
  end

  // Watch both buses, check results and guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(lrar_pkg::result_t'(m_axis_tdata));
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_draw(s_axis_tdata);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("lagged_rotate_add_random_unit regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offer one draw request; called and returns at a falling edge
  task automatic send_draw(input logic [31:0] modulus);
    while (src_gaps && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= modulus;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Hold the request side until every queued result has been received
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.reseed(seed);
  endtask

  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return $urandom_range(1, 32);
      3, 4:    return $urandom;
      5:       return 32'h1 << $urandom_range(0, 31);
      6:       return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    logic [31:0] edge_moduli [12];
    logic [31:0] seeds [5];

    edge_moduli = '{32'h0, 32'h1, 32'h2, 32'h3, 32'd17, 32'h0001_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0, 32'h5555_5555};
    seeds = '{32'hFFFF_FFFF, 32'h0, $urandom, 32'h1, 32'h8000_0000};
    sb.reseed('0);

    // Hold reset, release at a falling edge
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed draws from the reset seed
    foreach (edge_moduli[i]) send_draw(edge_moduli[i]);
    drain_results();

    // Random phases, each from a fresh seed
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      src_gaps  <= (p != 2);
      sink_gaps <= (p != 2);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 3 && n == ItemsPerPhase / 2) drain_results();
        send_draw(pick_modulus());
      end
      drain_results();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("lagged_rotate_add_random_unit regression: pass");
    end else begin
      $display("lagged_rotate_add_random_unit regression: fail");
    end
    $finish;
  end

endmodule
